/* src/gbu_pkg.sv */
// Shared types and constants for the gravity body update block.
package gbu_pkg;

    localparam int DATA_W     = 32;   // position / velocity / mass width
    localparam int TS_W       = 20;   // time step register width
    localparam int SC_W       = 7;    // substep count register width
    localparam int CFG_IDX_W  = 2;
    localparam int Q_W        = 31;   // scaled offset magnitude width
    localparam int SQ_W       = 64;   // sum of squares width
    localparam int ROOT_W     = 32;
    localparam int ROOT_STEPS = 32;   // two radicand bits per step
    localparam int G_W        = 56;   // 15 * mass * time_step
    localparam int GRAV_GAIN  = 15;

    localparam logic [TS_W-1:0] TS_RESET = 20'd655;
    localparam logic [SC_W-1:0] SC_RESET = 7'd1;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSTEPS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STATIC    = 2'd2;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_PULL   = 2'd1;
    localparam logic [1:0] MODE_DRIFT  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ,
        ST_SQ_ACC,
        ST_GAIN,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_K_WAIT,
        ST_N_WAIT,
        ST_DV_LO,
        ST_DV_HI,
        ST_DV_ADD,
        ST_DRIFT,
        ST_DRIFT_ADD,
        ST_DONE
    } state_t;

endpackage

/* src/gbu_shiftsub.sv */
// Iterative shift-subtract unit: restoring division or integer square root.
module gbu_shiftsub #(
    parameter int NUM_W = 72
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gbu_pkg::unit_ctl_t            ctl,
    input  logic [NUM_W-1:0]              num,
    input  logic [gbu_pkg::SQ_W-1:0]      den,
    output logic                          busy,
    output logic [NUM_W-1:0]              quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int REM_W = gbu_pkg::SQ_W + 2;

    logic                       busy_reg, busy_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    gbu_pkg::unit_op_t          op_reg, op_next;
    logic [NUM_W-1:0]           acc_reg, acc_next;
    logic [NUM_W-1:0]           quo_reg, quo_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [gbu_pkg::SQ_W-1:0]   den_reg, den_next;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] diff;
    logic             fits;

    always_comb
    begin
        if (op_reg == gbu_pkg::OP_SQRT)
        begin
            rem_sh = {rem_reg[REM_W-3:0], acc_reg[NUM_W-1 -: 2]};
            // trial = 4 * root + 1
            trial  = {{(REM_W-gbu_pkg::ROOT_W-2){1'b0}}, quo_reg[gbu_pkg::ROOT_W-1:0], 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[REM_W-2:0], acc_reg[NUM_W-1]};
            trial  = {2'b00, den_reg};
        end
        fits = (rem_sh >= trial);
        diff = rem_sh - trial;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            op_next   = ctl.op;
            acc_next  = num;
            quo_next  = '0;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = (ctl.op == gbu_pkg::OP_SQRT) ? CNT_W'(gbu_pkg::ROOT_STEPS)
                                                    : CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff : rem_sh;
            quo_next = {quo_reg[NUM_W-2:0], fits};
            acc_next = (op_reg == gbu_pkg::OP_SQRT) ? (acc_reg << 2) : (acc_reg << 1);
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= gbu_pkg::OP_DIV;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

/* src/gravity_body_update.sv */
// Top level: one-body gravity integrator with sequencer and shared datapath.
//
// Input channel (in_valid/in_ready) takes one request: mode 0 loads position
// and velocity, mode 1 presents another body, mode 2 drifts the own body.
// Output channel (out_valid/out_ready) returns one result per request: the
// body state afterwards plus zero_distance and saturated flags.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once; write them
// only while the block is idle.
// in_ready is high only while the sequencer is idle; one request is in work
// at a time. A request runs N = min(substep_count, MAX_SUBSTEPS) substeps:
//   load, static pull, unused mode or N = 0: no substeps, straight to the result
//   drift:  N substeps of position update
//   pull:   N substeps of velocity kick and drift; the shift-subtract unit
//           does one root and four divides per substep unless distance is zero
// A finished result sits in the output register; the next request is taken
// while it waits. If out_ready stays low, the following result holds in the
// sequencer until the register frees up.
// Reset clears position and velocity to zero and loads the register defaults.
module gravity_body_update #(
    parameter int FRAC_BITS    = 16,
    parameter int MAX_SUBSTEPS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gbu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbu_pkg::TS_W-1:0]           cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         mode,
    input  logic signed [31:0]                 pos_x,
    input  logic signed [31:0]                 pos_y,
    input  logic signed [31:0]                 pos_z,
    input  logic signed [31:0]                 load_vel_x,
    input  logic signed [31:0]                 load_vel_y,
    input  logic signed [31:0]                 load_vel_z,
    input  logic [31:0]                        other_mass,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [31:0]                 out_pos_x,
    output logic signed [31:0]                 out_pos_y,
    output logic signed [31:0]                 out_pos_z,
    output logic signed [31:0]                 out_vel_x,
    output logic signed [31:0]                 out_vel_y,
    output logic signed [31:0]                 out_vel_z,
    output logic                               zero_distance,
    output logic                               saturated
);

    localparam int NUM_W = gbu_pkg::G_W + FRAC_BITS;
    localparam int KW    = FRAC_BITS + 35;
    localparam int KH_W  = KW - FRAC_BITS;
    localparam int N_W   = FRAC_BITS + 1;
    localparam int CL_W  = 48;
    localparam logic [KW-1:0] K_MAX  = KW'(1) << (FRAC_BITS + 34);
    localparam logic [34:0]   DV_CAP = 35'(1) << 33;
    localparam int DW = gbu_pkg::DATA_W;

    function automatic logic [DW:0] clip32(input logic signed [CL_W-1:0] x);
        logic [DW:0] r;
        if (x > 48'sd2147483647)
            r = {1'b1, 32'h7fff_ffff};
        else if (x < -48'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, x[DW-1:0]};
        return r;
    endfunction

    // configuration
    logic [gbu_pkg::TS_W-1:0] time_step_reg;
    logic [gbu_pkg::SC_W-1:0] substep_count_reg;
    logic                     is_static_reg;

    // sequencer and datapath state
    gbu_pkg::state_t          state_reg, state_next;
    logic [1:0]               mode_reg, mode_next;
    logic signed [DW-1:0]     other_reg [3];
    logic signed [DW-1:0]     other_next [3];
    logic [DW-1:0]            mass_reg, mass_next;
    logic [gbu_pkg::SC_W-1:0] steps_reg, steps_next;
    logic [gbu_pkg::SC_W-1:0] step_cnt_reg, step_cnt_next;
    logic [1:0]               ax_reg, ax_next;
    logic signed [DW-1:0]     pos_reg [3];
    logic signed [DW-1:0]     pos_next [3];
    logic signed [DW-1:0]     vel_reg [3];
    logic signed [DW-1:0]     vel_next [3];
    logic [gbu_pkg::Q_W-1:0]  q_reg [3];
    logic [gbu_pkg::Q_W-1:0]  q_next [3];
    logic [2:0]               neg_reg, neg_next;
    logic                     shift_reg, shift_next;
    logic [gbu_pkg::SQ_W-1:0] ssum_reg, ssum_next;
    logic [gbu_pkg::G_W-1:0]  g_reg, g_next;
    logic [gbu_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [KW-1:0]            k_reg, k_next;
    logic [N_W-1:0]           n_reg, n_next;
    logic [FRAC_BITS-1:0]     lo_reg, lo_next;
    logic signed [68:0]       prod_reg;
    logic                     zd_reg, zd_next;
    logic                     sat_reg, sat_next;

    // output register
    logic                     out_valid_reg;
    logic signed [DW-1:0]     out_pos_reg [3];
    logic signed [DW-1:0]     out_vel_reg [3];
    logic                     out_zd_reg, out_sat_reg;
    logic                     out_load;

    // shared multiplier operands
    logic signed [35:0]       ma;
    logic signed [32:0]       mb;

    // shift-subtract unit
    gbu_pkg::unit_ctl_t       unit_ctl;
    logic [NUM_W-1:0]         unit_num;
    logic [gbu_pkg::SQ_W-1:0] unit_den;
    logic                     unit_busy;
    logic [NUM_W-1:0]         unit_quo;

    // offset evaluation
    logic signed [32:0]       d [3];
    logic [32:0]              a_mag [3];
    logic [gbu_pkg::Q_W-1:0]  q_new [3];
    logic                     any_big;
    logic                     all_zero;

    logic [gbu_pkg::SC_W-1:0] steps_cap;
    logic [1:0]               ax_inc;
    logic [KW-1:0]            k_raw;
    logic [68:0]              dv_sum;
    logic [34:0]              dv_c;
    logic signed [CL_W-1:0]   dv_s;
    logic signed [CL_W-1:0]   vel_sum;
    logic signed [CL_W-1:0]   pos_sum;
    logic signed [68:0]       drift_sh;
    logic [DW:0]              vel_clip;
    logic [DW:0]              pos_clip;

    gbu_shiftsub #(
        .NUM_W (NUM_W)
    ) u_shiftsub (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (unit_ctl),
        .num   (unit_num),
        .den   (unit_den),
        .busy  (unit_busy),
        .quo   (unit_quo)
    );

    always_comb
    begin
        any_big  = 1'b0;
        all_zero = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            d[i]     = 33'(other_reg[i]) - 33'(pos_reg[i]);
            a_mag[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
            any_big  = any_big | a_mag[i][32] | a_mag[i][31];
            all_zero = all_zero & (d[i] == 33'sd0);
        end
        for (int i = 0; i < 3; i++)
        begin
            q_new[i] = any_big ? a_mag[i][31:1] : a_mag[i][30:0];
        end
    end

    assign steps_cap = (32'(substep_count_reg) > MAX_SUBSTEPS) ? gbu_pkg::SC_W'(MAX_SUBSTEPS)
                                                                : substep_count_reg;
    assign ax_inc    = ax_reg + 2'd1;
    assign k_raw     = (|unit_quo[NUM_W-1:FRAC_BITS+34]) ? K_MAX : unit_quo[KW-1:0];

    // velocity kick: floor(k * n / 2^F), capped where the sum clips anyway
    assign dv_sum   = unsigned'(prod_reg) + 69'(lo_reg);
    assign dv_c     = (dv_sum > 69'(DV_CAP)) ? DV_CAP : dv_sum[34:0];
    assign dv_s     = neg_reg[ax_reg] ? -$signed({13'b0, dv_c}) : $signed({13'b0, dv_c});
    assign vel_sum  = CL_W'(vel_reg[ax_reg]) + dv_s;
    assign vel_clip = clip32(vel_sum);

    // drift: arithmetic shift gives the floor
    assign drift_sh = prod_reg >>> FRAC_BITS;
    assign pos_sum  = CL_W'(pos_reg[ax_reg]) + $signed(drift_sh[CL_W-1:0]);
    assign pos_clip = clip32(pos_sum);

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        other_next    = other_reg;
        mass_next     = mass_reg;
        steps_next    = steps_reg;
        step_cnt_next = step_cnt_reg;
        ax_next       = ax_reg;
        pos_next      = pos_reg;
        vel_next      = vel_reg;
        q_next        = q_reg;
        neg_next      = neg_reg;
        shift_next    = shift_reg;
        ssum_next     = ssum_reg;
        g_next        = g_reg;
        root_next     = root_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        lo_next       = lo_reg;
        zd_next       = zd_reg;
        sat_next      = sat_reg;
        unit_ctl.start = 1'b0;
        unit_ctl.op    = gbu_pkg::OP_DIV;
        unit_num      = '0;
        unit_den      = '0;
        ma            = '0;
        mb            = '0;
        out_load      = 1'b0;

        unique case (state_reg)
            gbu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next     = mode;
                    other_next[0] = pos_x;
                    other_next[1] = pos_y;
                    other_next[2] = pos_z;
                    mass_next     = other_mass;
                    steps_next    = steps_cap;
                    step_cnt_next = '0;
                    ax_next       = 2'd0;
                    zd_next       = 1'b0;
                    sat_next      = 1'b0;
                    if (mode == gbu_pkg::MODE_LOAD)
                    begin
                        pos_next[0] = pos_x;
                        pos_next[1] = pos_y;
                        pos_next[2] = pos_z;
                        vel_next[0] = load_vel_x;
                        vel_next[1] = load_vel_y;
                        vel_next[2] = load_vel_z;
                        state_next  = gbu_pkg::ST_DONE;
                    end
                    else if (mode == gbu_pkg::MODE_PULL && !is_static_reg && steps_cap != '0)
                        state_next = gbu_pkg::ST_DIFF;
                    else if (mode == gbu_pkg::MODE_DRIFT && steps_cap != '0)
                        state_next = gbu_pkg::ST_DRIFT;
                    else
                        state_next = gbu_pkg::ST_DONE;
                end
            end

            gbu_pkg::ST_DIFF:
            begin
                q_next     = q_new;
                neg_next   = {d[2][32], d[1][32], d[0][32]};
                shift_next = any_big;
                ssum_next  = '0;
                ax_next    = 2'd0;
                if (all_zero)
                begin
                    zd_next    = 1'b1;
                    state_next = gbu_pkg::ST_DRIFT;
                end
                else
                    state_next = gbu_pkg::ST_SQ;
            end

            gbu_pkg::ST_SQ:
            begin
                ma         = 36'(q_reg[ax_reg]);
                mb         = 33'(q_reg[ax_reg]);
                state_next = gbu_pkg::ST_SQ_ACC;
            end

            gbu_pkg::ST_SQ_ACC:
            begin
                ssum_next = ssum_reg + prod_reg[gbu_pkg::SQ_W-1:0];
                if (ax_reg == 2'd2)
                begin
                    ax_next    = 2'd0;
                    state_next = gbu_pkg::ST_GAIN;
                end
                else
                begin
                    ax_next    = ax_inc;
                    state_next = gbu_pkg::ST_SQ;
                end
            end

            gbu_pkg::ST_GAIN:
            begin
                ma         = 36'(mass_reg);
                mb         = 33'(time_step_reg);
                state_next = gbu_pkg::ST_ROOT;
            end

            gbu_pkg::ST_ROOT:
            begin
                g_next         = gbu_pkg::G_W'(prod_reg[51:0]) * gbu_pkg::G_W'(gbu_pkg::GRAV_GAIN);
                unit_ctl.start = 1'b1;
                unit_ctl.op    = gbu_pkg::OP_SQRT;
                unit_num       = NUM_W'(ssum_reg) << (NUM_W - gbu_pkg::SQ_W);
                state_next     = gbu_pkg::ST_ROOT_WAIT;
            end

            gbu_pkg::ST_ROOT_WAIT:
            begin
                if (!unit_busy)
                begin
                    root_next      = unit_quo[gbu_pkg::ROOT_W-1:0];
                    unit_ctl.start = 1'b1;
                    unit_num       = NUM_W'(g_reg) << FRAC_BITS;
                    unit_den       = ssum_reg;
                    state_next     = gbu_pkg::ST_K_WAIT;
                end
            end

            gbu_pkg::ST_K_WAIT:
            begin
                if (!unit_busy)
                begin
                    k_next         = shift_reg ? (k_raw >> 2) : k_raw;
                    unit_ctl.start = 1'b1;
                    unit_num       = NUM_W'({q_reg[ax_reg], {FRAC_BITS{1'b0}}});
                    unit_den       = gbu_pkg::SQ_W'(root_reg);
                    state_next     = gbu_pkg::ST_N_WAIT;
                end
            end

            gbu_pkg::ST_N_WAIT:
            begin
                if (!unit_busy)
                begin
                    n_next     = unit_quo[N_W-1:0];
                    state_next = gbu_pkg::ST_DV_LO;
                end
            end

            gbu_pkg::ST_DV_LO:
            begin
                ma         = 36'(k_reg[FRAC_BITS-1:0]);
                mb         = 33'(n_reg);
                state_next = gbu_pkg::ST_DV_HI;
            end

            gbu_pkg::ST_DV_HI:
            begin
                lo_next    = prod_reg[2*FRAC_BITS-1:FRAC_BITS];
                ma         = 36'(k_reg[KW-1 -: KH_W]);
                mb         = 33'(n_reg);
                state_next = gbu_pkg::ST_DV_ADD;
            end

            gbu_pkg::ST_DV_ADD:
            begin
                vel_next[ax_reg] = vel_clip[DW-1:0];
                sat_next         = sat_reg | vel_clip[DW];
                if (ax_reg == 2'd2)
                begin
                    ax_next    = 2'd0;
                    state_next = gbu_pkg::ST_DRIFT;
                end
                else
                begin
                    ax_next        = ax_inc;
                    unit_ctl.start = 1'b1;
                    unit_num       = NUM_W'({q_reg[ax_inc], {FRAC_BITS{1'b0}}});
                    unit_den       = gbu_pkg::SQ_W'(root_reg);
                    state_next     = gbu_pkg::ST_N_WAIT;
                end
            end

            gbu_pkg::ST_DRIFT:
            begin
                ma         = 36'(time_step_reg);
                mb         = 33'(vel_reg[ax_reg]);
                state_next = gbu_pkg::ST_DRIFT_ADD;
            end

            gbu_pkg::ST_DRIFT_ADD:
            begin
                pos_next[ax_reg] = pos_clip[DW-1:0];
                sat_next         = sat_reg | pos_clip[DW];
                if (ax_reg == 2'd2)
                begin
                    ax_next       = 2'd0;
                    step_cnt_next = step_cnt_reg + 1'b1;
                    if (step_cnt_next == steps_reg)
                        state_next = gbu_pkg::ST_DONE;
                    else if (mode_reg == gbu_pkg::MODE_PULL)
                        state_next = gbu_pkg::ST_DIFF;
                    else
                        state_next = gbu_pkg::ST_DRIFT;
                end
                else
                begin
                    ax_next    = ax_inc;
                    state_next = gbu_pkg::ST_DRIFT;
                end
            end

            gbu_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = gbu_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = gbu_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg     <= gbu_pkg::TS_RESET;
            substep_count_reg <= gbu_pkg::SC_RESET;
            is_static_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gbu_pkg::REG_TIME_STEP: time_step_reg     <= cfg_data;
                gbu_pkg::REG_SUBSTEPS:  substep_count_reg <= cfg_data[gbu_pkg::SC_W-1:0];
                gbu_pkg::REG_STATIC:    is_static_reg     <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbu_pkg::ST_IDLE;
            mode_reg      <= gbu_pkg::MODE_LOAD;
            steps_reg     <= '0;
            step_cnt_reg  <= '0;
            ax_reg        <= 2'd0;
            zd_reg        <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            steps_reg    <= steps_next;
            step_cnt_reg <= step_cnt_next;
            ax_reg       <= ax_next;
            zd_reg       <= zd_next;
            sat_reg      <= sat_next;
            pos_reg      <= pos_next;
            vel_reg      <= vel_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        other_reg <= other_next;
        mass_reg  <= mass_next;
        q_reg     <= q_next;
        neg_reg   <= neg_next;
        shift_reg <= shift_next;
        ssum_reg  <= ssum_next;
        g_reg     <= g_next;
        root_reg  <= root_next;
        k_reg     <= k_next;
        n_reg     <= n_next;
        lo_reg    <= lo_next;
        prod_reg  <= ma * mb;
        if (out_load)
        begin
            out_pos_reg <= pos_reg;
            out_vel_reg <= vel_reg;
            out_zd_reg  <= zd_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign in_ready      = (state_reg == gbu_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign out_pos_x     = out_pos_reg[0];
    assign out_pos_y     = out_pos_reg[1];
    assign out_pos_z     = out_pos_reg[2];
    assign out_vel_x     = out_vel_reg[0];
    assign out_vel_y     = out_vel_reg[1];
    assign out_vel_z     = out_vel_reg[2];
    assign zero_distance = out_zd_reg;
    assign saturated     = out_sat_reg;

    a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gbu_pkg::ST_IDLE) |-> !unit_busy)
        else $error("shift-subtract unit busy while sequencer idle");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != gbu_pkg::ST_IDLE) |-> (step_cnt_reg <= steps_reg))
        else $error("substep counter ran past its limit");

    a_zd_pull_only: assert property (@(posedge clk) disable iff (!rst_n)
        zd_reg |-> (mode_reg == gbu_pkg::MODE_PULL))
        else $error("zero distance flagged outside pull mode");

    a_load_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gbu_pkg::ST_DONE && mode_reg != gbu_pkg::MODE_PULL
            && mode_reg != gbu_pkg::MODE_DRIFT) |-> (!zd_reg && !sat_reg))
        else $error("flags raised on load or unused mode");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gbu_pkg::ST_DONE && out_valid_reg && !out_ready)
            |=> (state_reg == gbu_pkg::ST_DONE))
        else $error("result left the sequencer while output register was full");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for gravity_body_update: directed table, config corners and random requests.
`timescale 1ns / 100ps

module tb_top;

    localparam int FRAC = 16;
    localparam int MAXS = 64;
    localparam int WDOG_LIMIT = 400000;

    typedef struct {
        logic [1:0]         md;
        logic signed [31:0] p [3];
        logic signed [31:0] v [3];
        logic [31:0]        m;
    } body_req_t;

    typedef struct {
        logic signed [31:0] p [3];
        logic signed [31:0] v [3];
        logic               zd;
        logic               sat;
    } body_state_t;

    typedef struct {
        body_req_t   req;
        logic        known;
        body_state_t want;
    } table_row_t;

    logic clk, rst_n;
    logic cfg_we;
    logic [gbu_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gbu_pkg::TS_W-1:0] cfg_data;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [1:0] mode;
    logic signed [31:0] pos_x, pos_y, pos_z, load_vel_x, load_vel_y, load_vel_z;
    logic [31:0] other_mass;
    logic signed [31:0] out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z;
    logic zero_distance, saturated;

    gravity_body_update dut (.*);

    // predictor state
    longint body_pos [3];
    longint body_vel [3];
    longint cur_ts, cur_sc, cur_static;

    body_state_t expected_q [$];
    int mismatches = 0;
    int watchdog = 0;
    logic no_idle;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic longint clip_to32(longint x, ref bit flag);
        if (x > 64'sd2147483647)
        begin
            flag = 1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            flag = 1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint floor_frac(longint x);
        return x >>> FRAC;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void advance_position(ref bit sat);
        for (int i = 0; i < 3; i++)
            body_pos[i] = clip_to32(body_pos[i] + floor_frac(cur_ts * body_vel[i]), sat);
    endfunction

    function automatic void apply_gravity(longint other [3], longint unsigned mass,
                                          ref bit zd, ref bit sat);
        longint d [3];
        longint unsigned q [3];
        longint unsigned ssum, r, g, quo, k, n, dv;
        logic [127:0] wide;
        int sh;
        ssum = 0;
        sh = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = other[i] - body_pos[i];
            q[i] = d[i] < 0 ? -d[i] : d[i];
            if (q[i] >= 64'h8000_0000) sh = 1;
        end
        if (d[0] == 0 && d[1] == 0 && d[2] == 0)
        begin
            zd = 1;
            return;
        end
        for (int i = 0; i < 3; i++)
        begin
            q[i] >>= sh;
            ssum += q[i] * q[i];
        end
        r = root64(ssum);
        g = 15 * mass * cur_ts;
        quo = g / ssum;
        if (quo >= (64'd1 << 34))
            k = 64'd1 << (FRAC + 34);
        else
        begin
            wide = ({64'd0, g} << FRAC) / {64'd0, ssum};
            k = wide[63:0];
        end
        k >>= 2 * sh;
        for (int i = 0; i < 3; i++)
        begin
            n = (q[i] << FRAC) / r;
            dv = (k >> FRAC) * n + (((k & ((64'd1 << FRAC) - 1)) * n) >> FRAC);
            body_vel[i] = clip_to32(body_vel[i] + (d[i] < 0 ? -longint'(dv) : longint'(dv)),
                                    sat);
        end
    endfunction

    function automatic body_state_t predict_body(body_req_t rq);
        body_state_t res;
        bit zd, sat;
        longint other [3];
        longint steps;
        zd = 0;
        sat = 0;
        steps = cur_sc > MAXS ? MAXS : cur_sc;
        for (int i = 0; i < 3; i++) other[i] = rq.p[i];
        case (rq.md)
            gbu_pkg::MODE_LOAD:
                for (int i = 0; i < 3; i++)
                begin
                    body_pos[i] = rq.p[i];
                    body_vel[i] = rq.v[i];
                end
            gbu_pkg::MODE_PULL:
                if (cur_static == 0)
                    for (int j = 0; j < steps; j++)
                    begin
                        apply_gravity(other, rq.m, zd, sat);
                        advance_position(sat);
                    end
            gbu_pkg::MODE_DRIFT:
                for (int j = 0; j < steps; j++) advance_position(sat);
            default: ;
        endcase
        for (int i = 0; i < 3; i++)
        begin
            res.p[i] = body_pos[i][31:0];
            res.v[i] = body_vel[i][31:0];
        end
        res.zd = zd;
        res.sat = sat;
        return res;
    endfunction

    task automatic send_body(body_req_t rq);
        while (!no_idle && $urandom_range(99) < 10) @(posedge clk);
        in_valid <= 1;
        mode <= rq.md;
        pos_x <= rq.p[0];
        pos_y <= rq.p[1];
        pos_z <= rq.p[2];
        load_vel_x <= rq.v[0];
        load_vel_y <= rq.v[1];
        load_vel_z <= rq.v[2];
        other_mass <= rq.m;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_q = {expected_q, predict_body(rq)};
        in_valid <= 0;
        // in_ready is low for this cycle anyway
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [gbu_pkg::CFG_IDX_W-1:0] idx,
                             logic [gbu_pkg::TS_W-1:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
        if (idx == gbu_pkg::REG_TIME_STEP) cur_ts = val;
        else if (idx == gbu_pkg::REG_SUBSTEPS) cur_sc = val[gbu_pkg::SC_W-1:0];
        else if (idx == gbu_pkg::REG_STATIC) cur_static = val[0];
    endtask

    function automatic body_req_t make_req(logic [1:0] md, logic signed [31:0] a,
                                           logic signed [31:0] b, logic signed [31:0] c,
                                           logic signed [31:0] v, logic [31:0] m);
        body_req_t rq;
        rq.md = md;
        rq.p[0] = a;
        rq.p[1] = b;
        rq.p[2] = c;
        rq.v[0] = v;
        rq.v[1] = -v;
        rq.v[2] = v >>> 3;
        rq.m = m;
        return rq;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(200)) - 100 <<< 16;
            2: return $signed($urandom_range(2000000)) - 1000000;
            default: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        endcase
    endfunction

    function automatic body_req_t random_req();
        body_req_t rq;
        int sel;
        sel = $urandom_range(99);
        rq.md = sel < 15 ? gbu_pkg::MODE_LOAD : sel < 70 ? gbu_pkg::MODE_PULL
              : sel < 95 ? gbu_pkg::MODE_DRIFT : gbu_pkg::MODE_UNUSED;
        for (int i = 0; i < 3; i++)
        begin
            rq.p[i] = rand_coord();
            rq.v[i] = $urandom_range(1) ? $urandom : $signed($urandom_range(131072)) - 65536;
        end
        rq.m = $urandom_range(2) == 0 ? $urandom : $urandom_range(1 << 20);
        // occasionally aim at the own position to hit zero distance
        if (rq.md == gbu_pkg::MODE_PULL && $urandom_range(15) == 0)
            for (int i = 0; i < 3; i++) rq.p[i] = body_pos[i][31:0];
        return rq;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        body_state_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $time);
            end
            else
            begin
                w = expected_q.pop_front();
                if (w.p[0] !== out_pos_x || w.p[1] !== out_pos_y || w.p[2] !== out_pos_z
                    || w.v[0] !== out_vel_x || w.v[1] !== out_vel_y || w.v[2] !== out_vel_z
                    || w.zd !== zero_distance || w.sat !== saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t: exp p=%0d %0d %0d v=%0d %0d %0d zd=%0b sat=%0b",
                                 $time, w.p[0], w.p[1], w.p[2], w.v[0], w.v[1], w.v[2],
                                 w.zd, w.sat);
                        $display("  got p=%0d %0d %0d v=%0d %0d %0d zd=%0b sat=%0b",
                                 out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y,
                                 out_vel_z, zero_distance, saturated);
                    end
                end
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
        out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 10);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WDOG_LIMIT)
        begin
            $display("gravity_body_update verification failed");
            $finish;
        end
    end

    initial
    begin
        table_row_t rows [$];
        table_row_t row;
        body_state_t z;
        body_req_t rq;
        logic [gbu_pkg::TS_W-1:0] ts_val;

        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        in_valid = 0;
        mode = 0;
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
        load_vel_x = 0;
        load_vel_y = 0;
        load_vel_z = 0;
        other_mass = 0;
        no_idle = 0;
        for (int i = 0; i < 3; i++)
        begin
            body_pos[i] = 0;
            body_vel[i] = 0;
        end
        cur_ts = gbu_pkg::TS_RESET;
        cur_sc = gbu_pkg::SC_RESET;
        cur_static = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < 3; i++)
        begin
            z.p[i] = 0;
            z.v[i] = 0;
        end
        z.zd = 0;
        z.sat = 0;
        row.known = 1;
        row.want = z;
        row.req = make_req(gbu_pkg::MODE_UNUSED, 5, 6, 7, 8, 9);
        rows = {rows, row};                        // unused mode right after reset
        z.zd = 1;
        row.want = z;
        row.req = make_req(gbu_pkg::MODE_PULL, 0, 0, 0, 0, 32'hffff_ffff);
        rows = {rows, row};                        // zero distance at reset state
        row.req = make_req(gbu_pkg::MODE_LOAD, 32'sh7fff_ffff, 32'sh8000_0000, 0,
                           32'sh7fff_ffff, 0);
        row.want.p[0] = 32'sh7fff_ffff;
        row.want.p[1] = 32'sh8000_0000;
        row.want.p[2] = 0;
        row.want.v[0] = 32'sh7fff_ffff;
        row.want.v[1] = -32'sh7fff_ffff;
        row.want.v[2] = 32'sh7fff_ffff >>> 3;
        row.want.zd = 0;
        row.want.sat = 0;
        rows = {rows, row};
        row.known = 0;
        row.req = make_req(gbu_pkg::MODE_DRIFT, 0, 0, 0, 0, 0);
        rows = {rows, row};
        row.req = make_req(gbu_pkg::MODE_PULL, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                           0, 32'hffff_ffff);
        rows = {rows, row};
        row.req = make_req(gbu_pkg::MODE_LOAD, 0, 0, 0, 32'sh0001_0000, 0);
        rows = {rows, row};
        row.req = make_req(gbu_pkg::MODE_PULL, 32'sh0010_0000, 32'sh0000_8000, -32'sh0004_0000,
                           0, 32'h0100_0000);
        rows = {rows, row};
        row.req = make_req(gbu_pkg::MODE_PULL, 1, 0, 0, 0, 32'h0000_0001);
        rows = {rows, row};
        row.req = make_req(gbu_pkg::MODE_PULL, -32'sh0001_0000, 32'sh0003_0000, 0, 0, 0);
        rows = {rows, row};
        row.req = make_req(gbu_pkg::MODE_DRIFT, 0, 0, 0, 0, 0);
        rows = {rows, row};
        row.req = make_req(gbu_pkg::MODE_UNUSED, -1, -1, -1, -1, 32'hffff_ffff);
        rows = {rows, row};
        foreach (rows[i])
        begin
            send_body(rows[i].req);
            if (rows[i].known)
                expected_q[expected_q.size()-1] = rows[i].want;
        end
        drain_results();

        // configuration corners
        write_reg(gbu_pkg::REG_TIME_STEP, 20'hfffff);
        write_reg(gbu_pkg::REG_SUBSTEPS, 20'd127);  // above the maximum, clamps to 64
        send_body(make_req(gbu_pkg::MODE_LOAD, 0, 0, 0, 32'sh0100_0000, 0));
        send_body(make_req(gbu_pkg::MODE_DRIFT, 0, 0, 0, 0, 0));
        send_body(make_req(gbu_pkg::MODE_PULL, 32'sh0100_0000, 32'sh0200_0000, 5, 0,
                           32'hffff_ffff));
        drain_results();
        write_reg(gbu_pkg::REG_SUBSTEPS, 20'd0);
        send_body(make_req(gbu_pkg::MODE_DRIFT, 0, 0, 0, 0, 0));
        send_body(make_req(gbu_pkg::MODE_PULL, 100, 200, 300, 0, 77));
        drain_results();
        write_reg(gbu_pkg::REG_STATIC, 20'hffff1);  // only bit 0 matters
        write_reg(gbu_pkg::REG_SUBSTEPS, 20'd3);
        write_reg(gbu_pkg::REG_TIME_STEP, 20'd0);
        send_body(make_req(gbu_pkg::MODE_PULL, 100, 200, 300, 0, 77));
        send_body(make_req(gbu_pkg::MODE_DRIFT, 0, 0, 0, 0, 0));
        drain_results();
        write_reg(gbu_pkg::REG_STATIC, 20'h2);

        // random phases with varying settings
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 9)
                ts_val = 20'hfffff;
            else if ($urandom_range(1) != 0)
                ts_val = 20'($urandom_range(4096));
            else
                ts_val = 20'($urandom);
            write_reg(gbu_pkg::REG_TIME_STEP, ts_val);
            write_reg(gbu_pkg::REG_SUBSTEPS, ph == 8 ? 20'd64 : 20'($urandom_range(4)));
            write_reg(gbu_pkg::REG_STATIC, ($urandom_range(9) == 0) ? 20'($urandom) : 20'h0);
            no_idle = (ph == 4);
            for (int n = 0; n < (ph >= 8 ? 20 : 80); n++)
            begin
                rq = random_req();
                send_body(rq);
                if (ph == 2 && n == 40)
                    while (expected_q.size() != 0) @(posedge clk);
            end
            drain_results();
        end
        no_idle = 0;

        drain_results();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("gravity_body_update verification clean");
        else
            $display("gravity_body_update verification failed");
        $finish;
    end
endmodule

/* sim.f */
src/gbu_pkg.sv
src/gbu_shiftsub.sv
src/gravity_body_update.sv
tb/tb_top.sv
